// File: rtl/pbs_pkg.sv
// Shared package for the polyline bundle separation block.
// Holds the controller command codes, the status struct and the power table builder.
// No dependencies.
package pbs_pkg;

	localparam int unsigned FRAC_BITS_DEF = 16;
	localparam int unsigned POW_DEPTH_DEF = 256;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_DIFF,
		OP_SQX,
		OP_SQY,
		OP_SQRT,
		OP_ARC,
		OP_TSET,
		OP_TDIV,
		OP_TLAT,
		OP_IDX,
		OP_POW,
		OP_MULG,
		OP_UX,
		OP_UY,
		OP_MULY,
		OP_MULX,
		OP_SHY,
		OP_WRITE
	} op_t;

	typedef struct packed {
		logic pass;
		logic len_zero;
		logic t_one;
		logic sqrt_done;
		logic div_done;
	} status_t;

	// Largest Q2.30 y whose truncated fifth power stays at or below (k/(depth-1))^2.
	function automatic logic [31:0] pow_entry(input int unsigned k, input int unsigned depth);
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] mid;
		logic [63:0] uq;
		logic [63:0] u2;
		logic [63:0] y2;
		logic [63:0] y4;
		logic [63:0] y5;
		logic [63:0] kk;
		logic [63:0] dm1;
		begin
			kk = 64'(k);
			dm1 = 64'(depth) - 64'd1;
			// floor(k * 2^30 / (depth - 1)) found by search
			lo = 64'd0;
			hi = 64'd1 << 30;
			while (lo < hi) begin
				mid = (lo + hi + 64'd1) >> 1;
				if (mid * dm1 <= (kk << 30)) lo = mid;
				else hi = mid - 64'd1;
			end
			uq = lo;
			u2 = (uq * uq) >> 30;
			lo = 64'd0;
			hi = 64'd1 << 30;
			while (lo < hi) begin
				mid = (lo + hi + 64'd1) >> 1;
				y2 = (mid * mid) >> 30;
				y4 = (y2 * y2) >> 30;
				y5 = (y4 * mid) >> 30;
				if (y5 <= u2) lo = mid;
				else hi = mid - 64'd1;
			end
			return lo[31:0];
		end
	endfunction

endpackage

// File: rtl/polyline_bundle_separation.sv
// Polyline bundle separation: shifts interior edge points along the segment normal.
// A first or last point goes straight to the write; an interior point on a zero-length
// segment goes from the root to the write, and one whose t clamps to 1 skips the t division.
// One item at a time, the next taken the cycle after the result is written,
// even while that result waits.
// Reset (arst_n low): no result pending, previous point and arc distance cleared,
// gain back to 1.0. Depends on pbs_pkg, pbs_ctrl and pbs_dp.
module polyline_bundle_separation #(
	parameter int unsigned FRAC_BITS       = pbs_pkg::FRAC_BITS_DEF,
	parameter int unsigned POW_TABLE_DEPTH = pbs_pkg::POW_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               displacement_gain_we,
	input  logic signed [31:0] displacement_gain,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic [31:0]        edge_length,
	input  logic               first_point,
	input  logic               last_point,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic               out_last
);

	pbs_pkg::op_t     cmd;
	pbs_pkg::status_t status;

	pbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	pbs_dp #(
		.FRAC_BITS       (FRAC_BITS),
		.POW_TABLE_DEPTH (POW_TABLE_DEPTH)
	) u_dp (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cmd                  (cmd),
		.status               (status),
		.point_x              (point_x),
		.point_y              (point_y),
		.edge_length          (edge_length),
		.first_point          (first_point),
		.last_point           (last_point),
		.displacement_gain_we (displacement_gain_we),
		.displacement_gain    (displacement_gain),
		.out_x                (out_x),
		.out_y                (out_y),
		.out_last             (out_last)
	);

endmodule

// File: rtl/pbs_sqrt.sv
// Iterative integer square root, one result bit per cycle.
// Depends on nothing; used by pbs_dp.
module pbs_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] radicand,
	output logic [31:0] root,
	output logic        done
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [63:0] rad_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [35:0] shifted;
	logic [35:0] trial;

	assign shifted = {rem_q, rad_q[63:62]};
	assign trial   = {2'b00, root_q, 2'b01};
	assign root    = root_q;
	assign done    = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[61:0], 2'b00};
			if (shifted >= trial) begin
				rem_q  <= 34'(shifted - trial);
				root_q <= {root_q[30:0], 1'b1};
			end else begin
				rem_q  <= shifted[33:0];
				root_q <= {root_q[30:0], 1'b0};
			end
		end
	end

endmodule

// File: rtl/pbs_div.sv
// Iterative restoring divider giving a 31-bit quotient, one bit per cycle.
// Caller keeps the quotient below 2^31. Depends on nothing; used by pbs_dp.
module pbs_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	input  logic [32:0] den,
	output logic [30:0] quot,
	output logic        done
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [32:0] rem_q;
	logic [30:0] nsh_q;
	logic [32:0] den_q;
	logic [30:0] quot_q;
	logic [33:0] shifted;

	assign shifted = {rem_q, nsh_q[30]};
	assign quot    = quot_q;
	assign done    = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd30) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num[63:31];
			nsh_q  <= num[30:0];
			den_q  <= den;
			quot_q <= '0;
		end else if (busy_q) begin
			nsh_q <= {nsh_q[29:0], 1'b0};
			if (shifted >= {1'b0, den_q}) begin
				rem_q  <= 33'(shifted - {1'b0, den_q});
				quot_q <= {quot_q[29:0], 1'b1};
			end else begin
				rem_q  <= shifted[32:0];
				quot_q <= {quot_q[29:0], 1'b0};
			end
		end
	end

endmodule

// File: rtl/pbs_dp.sv
// Datapath: edge state, shared multiplier, power table and output register payload.
// Depends on pbs_pkg, pbs_sqrt and pbs_div; driven by pbs_ctrl commands.
module pbs_dp #(
	parameter int unsigned FRAC_BITS       = pbs_pkg::FRAC_BITS_DEF,
	parameter int unsigned POW_TABLE_DEPTH = pbs_pkg::POW_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pbs_pkg::op_t        cmd,
	output pbs_pkg::status_t    status,
	input  logic signed [31:0]  point_x,
	input  logic signed [31:0]  point_y,
	input  logic [31:0]         edge_length,
	input  logic                first_point,
	input  logic                last_point,
	input  logic                displacement_gain_we,
	input  logic signed [31:0]  displacement_gain,
	output logic signed [31:0]  out_x,
	output logic signed [31:0]  out_y,
	output logic                out_last
);

	localparam int unsigned IW = $clog2(POW_TABLE_DEPTH);
	localparam int unsigned PW = FRAC_BITS + 1 + IW;
	localparam logic [FRAC_BITS:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [FRAC_BITS:0] HALF = ONE >> 1;
	localparam logic [30:0] UNIT = 31'd1 << 30;

	logic [31:0] pow_tab [POW_TABLE_DEPTH];

	for (genvar k = 0; k < POW_TABLE_DEPTH; k++) begin : g_tab
		assign pow_tab[k] = pbs_pkg::pow_entry(k, POW_TABLE_DEPTH);
	end

	// edge state and register
	logic [31:0] prev_x_q;
	logic [31:0] prev_y_q;
	logic [31:0] arc_q;
	logic [31:0] gain_q;

	// item payload
	logic [31:0]        x_q;
	logic [31:0]        y_q;
	logic [31:0]        elen_q;
	logic               first_q;
	logic               last_q;
	logic [31:0]        ax_q;
	logic [31:0]        ay_q;
	logic               dxneg_q;
	logic               dyneg_q;
	logic               sh_q;
	logic [63:0]        mul_q;
	logic [63:0]        sum_q;
	logic [32:0]        len_q;
	logic               lzero_q;
	logic               tone_q;
	logic [FRAC_BITS:0] tq_q;
	logic [IW-1:0]      idx_q;
	logic [31:0]        p_q;
	logic [31:0]        m_q;
	logic [30:0]        ux_q;
	logic [31:0]        sxm_q;
	logic [31:0]        sym_q;
	logic [31:0]        out_x_q;
	logic [31:0]        out_y_q;
	logic               out_last_q;

	logic [32:0]        dx;
	logic [32:0]        dy;
	logic [32:0]        adx;
	logic [32:0]        ady;
	logic [31:0]        mul_a;
	logic [31:0]        mul_b;
	logic [63:0]        prod;
	logic [31:0]        gain_abs;
	logic [31:0]        sq_root;
	logic               sq_done;
	logic [32:0]        len_c;
	logic [33:0]        arc_sum;
	logic [31:0]        arc_new;
	logic               div_start;
	logic [63:0]        div_num;
	logic [32:0]        div_den;
	logic [30:0]        div_quot;
	logic               div_done;
	logic [30:0]        unit_c;
	logic [FRAC_BITS:0] dev;
	logic [FRAC_BITS:0] u_c;
	logic [PW-1:0]      idx_full;
	logic [IW-1:0]      idx_c;
	logic               sx_neg;
	logic               sy_neg;
	logic signed [33:0] sum_x;
	logic signed [33:0] sum_y;
	logic [31:0]        sat_x;
	logic [31:0]        sat_y;

	assign dx  = {x_q[31], x_q} - {prev_x_q[31], prev_x_q};
	assign dy  = {y_q[31], y_q} - {prev_y_q[31], prev_y_q};
	assign adx = dx[32] ? 33'(~dx + 33'd1) : dx;
	assign ady = dy[32] ? 33'(~dy + 33'd1) : dy;

	assign gain_abs = gain_q[31] ? 32'(~gain_q + 32'd1) : gain_q;
	assign unit_c   = (div_quot > UNIT) ? UNIT : div_quot;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd)
			pbs_pkg::OP_SQX: begin
				mul_a = sh_q ? (ax_q >> 1) : ax_q;
				mul_b = mul_a;
			end
			pbs_pkg::OP_SQY: begin
				mul_a = sh_q ? (ay_q >> 1) : ay_q;
				mul_b = mul_a;
			end
			pbs_pkg::OP_MULG: begin
				mul_a = gain_abs;
				mul_b = p_q;
			end
			pbs_pkg::OP_MULY: begin
				mul_a = m_q;
				mul_b = {1'b0, unit_c};
			end
			pbs_pkg::OP_MULX: begin
				mul_a = m_q;
				mul_b = {1'b0, ux_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = 64'(mul_a) * 64'(mul_b);

	pbs_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd == pbs_pkg::OP_SQRT),
		.radicand (sum_q + mul_q),
		.root     (sq_root),
		.done     (sq_done)
	);

	assign len_c   = sh_q ? {sq_root, 1'b0} : {1'b0, sq_root};
	assign arc_sum = {2'b00, arc_q} + {1'b0, len_c};
	assign arc_new = (arc_sum[33:32] != 2'b00) ? 32'hFFFF_FFFF : arc_sum[31:0];

	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		case (cmd)
			pbs_pkg::OP_TDIV: begin
				div_start = 1'b1;
				div_num   = 64'(arc_q) << FRAC_BITS;
				div_den   = {1'b0, elen_q};
			end
			pbs_pkg::OP_UX: begin
				div_start = 1'b1;
				div_num   = {2'b00, ax_q, 30'd0};
				div_den   = len_q;
			end
			pbs_pkg::OP_UY: begin
				div_start = 1'b1;
				div_num   = {2'b00, ay_q, 30'd0};
				div_den   = len_q;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	pbs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.quot   (div_quot),
		.done   (div_done)
	);

	// weight u = 1 - 2|t - 1/2|, then round onto the table index
	assign dev      = (tq_q >= HALF) ? (tq_q - HALF) : (HALF - tq_q);
	assign u_c      = ONE - (dev << 1);
	assign idx_full = (PW'(u_c) * PW'(POW_TABLE_DEPTH - 1) + PW'(HALF)) >> FRAC_BITS;
	assign idx_c    = (idx_full > PW'(POW_TABLE_DEPTH - 1)) ? IW'(POW_TABLE_DEPTH - 1)
	                                                        : idx_full[IW-1:0];

	assign sx_neg = gain_q[31] ^ dyneg_q;
	assign sy_neg = ~(gain_q[31] ^ dxneg_q);
	assign sum_x  = $signed({{2{x_q[31]}}, x_q})
	              + (sx_neg ? -$signed({2'b00, sxm_q}) : $signed({2'b00, sxm_q}));
	assign sum_y  = $signed({{2{y_q[31]}}, y_q})
	              + (sy_neg ? -$signed({2'b00, sym_q}) : $signed({2'b00, sym_q}));

	always_comb begin
		if (sum_x > 34'sh0_7FFF_FFFF)       sat_x = 32'h7FFF_FFFF;
		else if (sum_x < -34'sh0_8000_0000) sat_x = 32'h8000_0000;
		else                                sat_x = sum_x[31:0];
		if (sum_y > 34'sh0_7FFF_FFFF)       sat_y = 32'h7FFF_FFFF;
		else if (sum_y < -34'sh0_8000_0000) sat_y = 32'h8000_0000;
		else                                sat_y = sum_y[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q <= '0;
			prev_y_q <= '0;
			arc_q    <= '0;
			gain_q   <= 32'h0001_0000;
		end else begin
			if (displacement_gain_we) gain_q <= displacement_gain;
			if (cmd == pbs_pkg::OP_ARC) arc_q <= arc_new;
			if (cmd == pbs_pkg::OP_WRITE) begin
				if (first_q) begin
					prev_x_q <= x_q;
					prev_y_q <= y_q;
					arc_q    <= '0;
				end else if (last_q) begin
					arc_q <= '0;
				end else begin
					prev_x_q <= x_q;
					prev_y_q <= y_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd)
			pbs_pkg::OP_LOAD: begin
				x_q     <= point_x;
				y_q     <= point_y;
				elen_q  <= edge_length;
				first_q <= first_point;
				last_q  <= last_point;
				sxm_q   <= '0;
				sym_q   <= '0;
			end
			pbs_pkg::OP_DIFF: begin
				ax_q    <= adx[31:0];
				ay_q    <= ady[31:0];
				dxneg_q <= dx[32];
				dyneg_q <= dy[32];
				sh_q    <= adx[31] | ady[31];
			end
			pbs_pkg::OP_SQX: mul_q <= prod;
			pbs_pkg::OP_SQY: begin
				sum_q <= mul_q;
				mul_q <= prod;
			end
			pbs_pkg::OP_ARC: begin
				len_q   <= len_c;
				lzero_q <= (sq_root == 32'd0);
				tone_q  <= (elen_q == 32'd0) || (arc_new >= elen_q);
			end
			pbs_pkg::OP_TSET: tq_q  <= ONE;
			pbs_pkg::OP_TLAT: tq_q  <= div_quot[FRAC_BITS:0];
			pbs_pkg::OP_IDX:  idx_q <= idx_c;
			pbs_pkg::OP_POW:  p_q   <= pow_tab[idx_q];
			pbs_pkg::OP_MULG: mul_q <= prod;
			pbs_pkg::OP_UX:   m_q   <= mul_q[61:30];
			pbs_pkg::OP_UY:   ux_q  <= unit_c;
			pbs_pkg::OP_MULY: mul_q <= prod;
			pbs_pkg::OP_MULX: begin
				sxm_q <= mul_q[61:30];
				mul_q <= prod;
			end
			pbs_pkg::OP_SHY: sym_q <= mul_q[61:30];
			pbs_pkg::OP_WRITE: begin
				out_x_q    <= sat_x;
				out_y_q    <= sat_y;
				out_last_q <= last_q;
			end
			default: begin
			end
		endcase
	end

	assign status.pass      = first_q | last_q;
	assign status.len_zero  = lzero_q;
	assign status.t_one     = tone_q;
	assign status.sqrt_done = sq_done;
	assign status.div_done  = div_done;

	assign out_x    = out_x_q;
	assign out_y    = out_y_q;
	assign out_last = out_last_q;

endmodule

// File: rtl/pbs_ctrl.sv
// Controller: sequences one point through the datapath and owns both handshakes.
// Depends on pbs_pkg; issues op codes to pbs_dp and reads its status.
module pbs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	input  pbs_pkg::status_t status,
	output pbs_pkg::op_t     cmd
);

	typedef enum logic [4:0] {
		S_IDLE, S_DIFF, S_SQX, S_SQY, S_SQRT, S_SQRT_W, S_ARC, S_TCHK, S_TSET,
		S_TDIV, S_TDIV_W, S_TLAT, S_IDX, S_POW, S_MULG, S_UX, S_UX_W, S_UY,
		S_UY_W, S_MULY, S_MULX, S_SHY, S_WRITE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = ~out_valid_q | ~out_stall;

	always_comb begin
		unique case (state_q)
			S_IDLE:   cmd = in_valid ? pbs_pkg::OP_LOAD : pbs_pkg::OP_NONE;
			S_DIFF:   cmd = pbs_pkg::OP_DIFF;
			S_SQX:    cmd = pbs_pkg::OP_SQX;
			S_SQY:    cmd = pbs_pkg::OP_SQY;
			S_SQRT:   cmd = pbs_pkg::OP_SQRT;
			S_ARC:    cmd = pbs_pkg::OP_ARC;
			S_TSET:   cmd = pbs_pkg::OP_TSET;
			S_TDIV:   cmd = pbs_pkg::OP_TDIV;
			S_TLAT:   cmd = pbs_pkg::OP_TLAT;
			S_IDX:    cmd = pbs_pkg::OP_IDX;
			S_POW:    cmd = pbs_pkg::OP_POW;
			S_MULG:   cmd = pbs_pkg::OP_MULG;
			S_UX:     cmd = pbs_pkg::OP_UX;
			S_UY:     cmd = pbs_pkg::OP_UY;
			S_MULY:   cmd = pbs_pkg::OP_MULY;
			S_MULX:   cmd = pbs_pkg::OP_MULX;
			S_SHY:    cmd = pbs_pkg::OP_SHY;
			S_WRITE:  cmd = out_free ? pbs_pkg::OP_WRITE : pbs_pkg::OP_NONE;
			default:  cmd = pbs_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE:   if (in_valid) state_q <= S_DIFF;
				S_DIFF:   state_q <= status.pass ? S_WRITE : S_SQX;
				S_SQX:    state_q <= S_SQY;
				S_SQY:    state_q <= S_SQRT;
				S_SQRT:   state_q <= S_SQRT_W;
				S_SQRT_W: if (status.sqrt_done) state_q <= S_ARC;
				S_ARC:    state_q <= S_TCHK;
				S_TCHK: begin
					if (status.len_zero)   state_q <= S_WRITE;
					else if (status.t_one) state_q <= S_TSET;
					else                   state_q <= S_TDIV;
				end
				S_TSET:   state_q <= S_IDX;
				S_TDIV:   state_q <= S_TDIV_W;
				S_TDIV_W: if (status.div_done) state_q <= S_TLAT;
				S_TLAT:   state_q <= S_IDX;
				S_IDX:    state_q <= S_POW;
				S_POW:    state_q <= S_MULG;
				S_MULG:   state_q <= S_UX;
				S_UX:     state_q <= S_UX_W;
				S_UX_W:   if (status.div_done) state_q <= S_UY;
				S_UY:     state_q <= S_UY_W;
				S_UY_W:   if (status.div_done) state_q <= S_MULY;
				S_MULY:   state_q <= S_MULX;
				S_MULX:   state_q <= S_SHY;
				S_SHY:    state_q <= S_WRITE;
				S_WRITE: begin
					// hold until the output register can take the result
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default:  state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/pbs_checker.sv
// Port-level checks for polyline_bundle_separation, attached by bind.
// Depends only on the top level's ports.
module pbs_props (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] out_x,
	input logic [31:0] out_y,
	input logic        out_last
);

	logic [1:0] pending_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid & ~in_stall;
	assign out_acc = out_valid & ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pending_q <= '0;
		else pending_q <= 2'(pending_q + {1'b0, in_acc} - {1'b0, out_acc});
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(out_y)
		&& $stable(out_last))
		else $error("result changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> in_stall)
		else $error("new item taken while one is in work");

	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 2'd0)
		else $error("result shown with no item outstanding");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("more than two items outstanding");

endmodule

bind polyline_bundle_separation pbs_props u_pbs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_x     (out_x),
	.out_y     (out_y),
	.out_last  (out_last)
);
